// ===== hdl/bv_to_av_id_decoder_assert.svh =====
// Assertion macros for the video ID decoder.
`ifndef BV_TO_AV_ID_DECODER_ASSERT_SVH
`define BV_TO_AV_ID_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BVID_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BVID_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bvid_pkg.sv =====
// Types, constants and character tables for the video ID decoder.
`default_nettype none

package bvid_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ILLEGAL   = 3'd1,
    ST_FORBIDDEN = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  localparam int unsigned DigitW  = 6;
  localparam int unsigned WeightW = 53;  // 58^9 fits in 53 bits
  localparam int unsigned ProdW   = 59;  // 57 * 58^9 fits in 59 bits
  localparam int unsigned AccW    = 64;
  localparam int unsigned IdW     = 27;
  localparam int unsigned PosW    = 4;

  localparam logic [PosW-1:0] MaxChars = 4'd10;
  localparam logic [AccW-1:0] IdOffset = 64'd100618342136696320;
  localparam logic [AccW-1:0] IdKey    = 64'd177451812;
  localparam logic [IdW-1:0]  IdLimit  = 27'd100000000;
  // Accumulator is kept biased by -offset so the final step is add, xor, compare.
  localparam logic [AccW-1:0] AccInit  = ~IdOffset + 64'd1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0] id_value;
    logic [2:0]     status;
  } out_beat_t;

  // One decoded character, ready to be accumulated.
  typedef struct packed {
    logic             valid;
    logic             last;
    status_e          err;
    logic [ProdW-1:0] prod;
  } term_t;

  function automatic status_e char_class(input logic [7:0] c);
    status_e cls;
    unique case (c) inside
      ["0":"9"], ["A":"Z"], ["a":"z"]: cls = ST_OK;
      default:                         cls = ST_ILLEGAL;
    endcase
    unique case (c) inside
      "0", "I", "O", "l": cls = ST_FORBIDDEN;
      default:            cls = cls;
    endcase
    return cls;
  endfunction

  function automatic logic [DigitW-1:0] char_digit(input logic [7:0] c);
    logic [DigitW-1:0] d;
    unique case (c)
      "f": d = 6'd0;   "Z": d = 6'd1;   "o": d = 6'd2;   "d": d = 6'd3;
      "R": d = 6'd4;   "9": d = 6'd5;   "X": d = 6'd6;   "Q": d = 6'd7;
      "D": d = 6'd8;   "S": d = 6'd9;   "U": d = 6'd10;  "m": d = 6'd11;
      "2": d = 6'd12;  "1": d = 6'd13;  "y": d = 6'd14;  "C": d = 6'd15;
      "k": d = 6'd16;  "r": d = 6'd17;  "6": d = 6'd18;  "z": d = 6'd19;
      "B": d = 6'd20;  "q": d = 6'd21;  "i": d = 6'd22;  "v": d = 6'd23;
      "e": d = 6'd24;  "Y": d = 6'd25;  "a": d = 6'd26;  "h": d = 6'd27;
      "8": d = 6'd28;  "b": d = 6'd29;  "t": d = 6'd30;  "4": d = 6'd31;
      "x": d = 6'd32;  "s": d = 6'd33;  "W": d = 6'd34;  "p": d = 6'd35;
      "H": d = 6'd36;  "n": d = 6'd37;  "J": d = 6'd38;  "E": d = 6'd39;
      "7": d = 6'd40;  "j": d = 6'd41;  "L": d = 6'd42;  "5": d = 6'd43;
      "V": d = 6'd44;  "G": d = 6'd45;  "3": d = 6'd46;  "g": d = 6'd47;
      "u": d = 6'd48;  "M": d = 6'd49;  "T": d = 6'd50;  "K": d = 6'd51;
      "N": d = 6'd52;  "P": d = 6'd53;  "A": d = 6'd54;  "w": d = 6'd55;
      "c": d = 6'd56;  "F": d = 6'd57;
      default: d = 6'd0;
    endcase
    return d;
  endfunction

  // Power of 58 for each character position (positions are permuted).
  function automatic logic [WeightW-1:0] pos_weight(input logic [PosW-1:0] pos);
    logic [WeightW-1:0] w;
    unique case (pos)
      4'd0:    w = 53'd38068692544;
      4'd1:    w = 53'd3364;
      4'd2:    w = 53'd11316496;
      4'd3:    w = 53'd128063081718016;
      4'd4:    w = 53'd656356768;
      4'd5:    w = 53'd7427658739644928;
      4'd6:    w = 53'd195112;
      4'd7:    w = 53'd2207984167552;
      4'd8:    w = 53'd58;
      4'd9:    w = 53'd1;
      default: w = 53'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bv_to_av_id_decoder.sv =====
// Video ID decoder top: input register, character stage, accumulator, result register.
//
//   channel | signals                          | beat
//   --------+----------------------------------+----------------------------
//   in      | in_valid_i  in_ready_o  in_beat_i | one ID character + last flag
//   out     | out_valid_o out_ready_i out_beat_o| decoded ID + status, per ID
//
// One character is taken every cycle unless stalled; the accumulator add is the
// per-cycle loop. A result passes through the input and character stage registers
// into the output register. The pipeline stalls only when a last character reaches
// the accumulator while the previous result is still held and not taken.
// Reset clears valid flags, position, sticky error and the biased accumulator.
`default_nettype none

`include "bv_to_av_id_decoder_assert.svh"

module bv_to_av_id_decoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire bvid_pkg::in_beat_t  in_beat_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      bvid_pkg::out_beat_t out_beat_o
);

  logic                       en;
  logic                       a_valid_q;
  bvid_pkg::in_beat_t         a_beat_q;
  bvid_pkg::term_t            term;
  logic [bvid_pkg::AccW-1:0]  acc_q, acc_d;
  bvid_pkg::status_e          sticky_q, sticky_d;
  logic [bvid_pkg::AccW-1:0]  sum;
  logic [bvid_pkg::AccW-1:0]  keyed;
  bvid_pkg::status_e          res_status;
  logic                       out_valid_q, out_valid_d;
  bvid_pkg::out_beat_t        out_beat_q, out_beat_d;
  logic                       res_fire;

  // hold everything while a finished ID cannot get into the output register
  assign en         = !(term.valid && term.last && out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign res_fire   = en && term.valid && term.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      a_beat_q <= in_beat_i;
    end
  end

  bvid_char_stage u_char_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(a_valid_q),
    .beat_i (a_beat_q),
    .term_o (term)
  );

  always_comb begin
    sum   = acc_q + bvid_pkg::AccW'(term.prod);
    keyed = sum ^ bvid_pkg::IdKey;

    if (sticky_q != bvid_pkg::ST_OK) begin
      res_status = sticky_q;
    end else if (term.err != bvid_pkg::ST_OK) begin
      res_status = term.err;
    end else if (keyed[bvid_pkg::AccW-1:bvid_pkg::IdW] != '0 ||
                 keyed[bvid_pkg::IdW-1:0] >= bvid_pkg::IdLimit) begin
      res_status = bvid_pkg::ST_RANGE;
    end else begin
      res_status = bvid_pkg::ST_OK;
    end

    acc_d    = acc_q;
    sticky_d = sticky_q;
    if (en && term.valid) begin
      if (term.last) begin
        acc_d    = bvid_pkg::AccInit;
        sticky_d = bvid_pkg::ST_OK;
      end else if (sticky_q == bvid_pkg::ST_OK) begin
        if (term.err == bvid_pkg::ST_OK) begin
          acc_d = sum;
        end else begin
          sticky_d = term.err;
        end
      end
    end

    out_beat_d.status   = res_status;
    out_beat_d.id_value = (res_status == bvid_pkg::ST_OK) ? keyed[bvid_pkg::IdW-1:0] : '0;

    out_valid_d = out_valid_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= bvid_pkg::AccInit;
      sticky_q    <= bvid_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // an error result never carries an ID
  `BVID_ASSERT_IMP(a_err_id_zero, out_valid_q && out_beat_q.status != bvid_pkg::ST_OK, out_beat_q.id_value == '0, "error beat with nonzero ID")

  // state is back to its reset values after each result
  `BVID_ASSERT_NXT(a_clear_after_id, res_fire, sticky_q == bvid_pkg::ST_OK && acc_q == bvid_pkg::AccInit, "state not cleared after ID")

  // the first error of an ID sticks until its result
  `BVID_ASSERT_NXT(a_sticky_holds, sticky_q != bvid_pkg::ST_OK && !res_fire, sticky_q == $past(sticky_q), "sticky error changed")

endmodule

`default_nettype wire

// ===== hdl/bvid_char_stage.sv =====
// Character stage: validation, digit lookup and weighted term, with the position counter.
`default_nettype none

module bvid_char_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire bvid_pkg::in_beat_t beat_i,
  output bvid_pkg::term_t       term_o
);

  logic [bvid_pkg::PosW-1:0]    pos_q, pos_d;
  logic                         valid_q;
  logic                         last_q;
  bvid_pkg::status_e            err_q, err_d;
  logic [bvid_pkg::ProdW-1:0]   prod_q, prod_d;
  bvid_pkg::status_e            cls;
  logic [bvid_pkg::DigitW-1:0]  digit;
  logic [bvid_pkg::WeightW-1:0] weight;

  always_comb begin
    cls    = bvid_pkg::char_class(beat_i.char_code);
    digit  = bvid_pkg::char_digit(beat_i.char_code);
    weight = bvid_pkg::pos_weight(pos_q);
    prod_d = bvid_pkg::ProdW'(digit) * bvid_pkg::ProdW'(weight);
    // character check wins over the length check
    if (cls == bvid_pkg::ST_OK && pos_q >= bvid_pkg::MaxChars) begin
      err_d = bvid_pkg::ST_TOO_LONG;
    end else begin
      err_d = cls;
    end
    pos_d = pos_q;
    if (en_i && valid_i) begin
      if (beat_i.last) begin
        pos_d = '0;
      end else if (pos_q < bvid_pkg::MaxChars) begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (en_i) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      last_q <= beat_i.last;
      err_q  <= err_d;
      prod_q <= prod_d;
    end
  end

  assign term_o.valid = valid_q;
  assign term_o.last  = last_q;
  assign term_o.err   = err_q;
  assign term_o.prod  = prod_q;

endmodule

`default_nettype wire
